/* hw/rtl/sgpp_pkg.sv */
// ----------------------------------------------------------------------------
// sgpp_pkg
// shared types and constants of the servo goal position planner
// ----------------------------------------------------------------------------
package sgpp_pkg;

    localparam int TICK_W         = 12;
    localparam int TICKS_PER_TURN = 4096;
    localparam int HALF_TURN      = TICKS_PER_TURN / 2;
    localparam int RAW_W          = 32;
    localparam int REG_W          = 13;
    localparam int GOAL_W         = 14;
    localparam int DIV_STEPS      = RAW_W;

    typedef enum logic [1:0] {
        MODE_SHORTEST = 2'd0,
        MODE_CW       = 2'd1,
        MODE_CCW      = 2'd2,
        MODE_LIMITED  = 2'd3
    } move_mode_t;

    typedef enum logic [1:0] {
        REG_POSITION_SCALE = 2'd0,
        REG_REVERSE_LIMIT  = 2'd1,
        REG_FORWARD_LIMIT  = 2'd2,
        REG_NONE           = 2'd3
    } reg_index_t;

    localparam logic [REG_W-1:0] SCALE_RESET   = 13'd340;
    localparam logic [REG_W-1:0] REVERSE_RESET = 13'd0;
    localparam logic [REG_W-1:0] FORWARD_RESET = 13'd3868;

endpackage

/* hw/rtl/servo_goal_position_planner.sv */
// ----------------------------------------------------------------------------
// servo_goal_position_planner
// turns a target angle and a raw position reading into a goal position
// ----------------------------------------------------------------------------
// One command beat on the input channel (target_ticks, present_raw,
// move_mode) gives exactly one result beat (goal_ticks, goal_raw, at_limit).
// The raw reading is divided by position_scale in a restoring divider that
// retires one quotient bit per stage, 32 stages, followed by a limit shift
// stage, a path select stage and a multiply stage that holds the result.
// A new command is taken every cycle as long as results drain.
// The whole pipeline advances together: when the result waits on out_ready
// every stage holds and in_ready drops, so nothing is lost or repeated.
// Registers are written via cfg_we/cfg_index/cfg_wdata; the user must write
// them only while no command is in flight (not enforced); index 3 is ignored.
// Reset clears all stage valid bits and loads the register reset values
// (scale 340, reverse limit 0, forward limit 3868).
// ----------------------------------------------------------------------------
module servo_goal_position_planner (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_index,
    input  logic [sgpp_pkg::REG_W-1:0]      cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [sgpp_pkg::TICK_W-1:0]     target_ticks,
    input  logic [sgpp_pkg::RAW_W-1:0]      present_raw,
    input  logic [1:0]                      move_mode,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [sgpp_pkg::GOAL_W-1:0] goal_ticks,
    output logic [sgpp_pkg::RAW_W-1:0]      goal_raw,
    output logic                            at_limit
);
    import sgpp_pkg::*;

    logic [REG_W-1:0] scale_reg, rev_reg, fwd_reg;
    logic [REG_W-1:0] sc;
    logic             en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
            rev_reg   <= REVERSE_RESET;
            fwd_reg   <= FORWARD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_POSITION_SCALE: scale_reg <= cfg_wdata;
                REG_REVERSE_LIMIT:  rev_reg   <= cfg_wdata;
                REG_FORWARD_LIMIT:  fwd_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // zero scale acts as one
    assign sc = (scale_reg == '0) ? REG_W'(1) : scale_reg;

    // ---------------- divider stages ----------------
    logic [DIV_STEPS-1:0]  dv_reg;
    logic [REG_W-1:0]      rem_reg  [DIV_STEPS];
    logic [RAW_W-1:0]      dvd_reg  [DIV_STEPS];
    logic [TICK_W-1:0]     q_reg    [DIV_STEPS];
    logic [TICK_W-1:0]     tgt_reg  [DIV_STEPS];
    move_mode_t            mode_reg [DIV_STEPS];

    logic [REG_W-1:0]      rem_next [DIV_STEPS];
    logic [RAW_W-1:0]      dvd_next [DIV_STEPS];
    logic [TICK_W-1:0]     q_next   [DIV_STEPS];

    always_comb
    begin
        logic [REG_W:0]   rr;
        logic [REG_W-1:0] rin;
        logic [RAW_W-1:0] din;
        logic [TICK_W-1:0] qin;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            if (k == 0)
            begin
                rin = '0;
                din = present_raw;
                qin = '0;
            end
            else
            begin
                rin = rem_reg[k-1];
                din = dvd_reg[k-1];
                qin = q_reg[k-1];
            end
            rr = {rin, din[RAW_W-1]};
            if (rr >= {1'b0, sc})
            begin
                rem_next[k] = REG_W'(rr - {1'b0, sc});
                q_next[k]   = {qin[TICK_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = rr[REG_W-1:0];
                q_next[k]   = {qin[TICK_W-2:0], 1'b0};
            end
            dvd_next[k] = {din[RAW_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_reg <= '0;
        else if (en)
            dv_reg <= {dv_reg[DIV_STEPS-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                rem_reg[k] <= rem_next[k];
                dvd_reg[k] <= dvd_next[k];
                q_reg[k]   <= q_next[k];
                if (k == 0)
                begin
                    tgt_reg[k]  <= target_ticks;
                    mode_reg[k] <= move_mode_t'(move_mode);
                end
                else
                begin
                    tgt_reg[k]  <= tgt_reg[k-1];
                    mode_reg[k] <= mode_reg[k-1];
                end
            end
        end
    end

    // ---------------- shift around the limit midpoint ----------------
    logic [TICK_W-1:0] cur_d, tgt_d;
    logic [REG_W+1:0]  mid_sum;
    logic [TICK_W-1:0] mid;
    logic              s1_v_reg;
    logic [TICK_W-1:0] s1_cur_reg, s1_tgt_reg, s1_cura_reg, s1_tgta_reg;
    logic [TICK_W-1:0] s1_fwda_reg, s1_reva_reg;
    move_mode_t        s1_mode_reg;

    assign cur_d = q_reg[DIV_STEPS-1];
    assign tgt_d = tgt_reg[DIV_STEPS-1];

    always_comb
    begin
        mid_sum = (REG_W+2)'(fwd_reg) + (REG_W+2)'(rev_reg);
        if (fwd_reg > rev_reg)
            mid_sum = mid_sum + (REG_W+2)'(TICKS_PER_TURN);
    end
    assign mid = mid_sum[TICK_W:1];

    function automatic logic [TICK_W-1:0] shift_mid(input logic [REG_W-1:0] x,
                                                    input logic [TICK_W-1:0] m);
        logic [REG_W+1:0] t;
        t = (REG_W+2)'(x) - (REG_W+2)'(m) + (REG_W+2)'(TICKS_PER_TURN);
        return t[TICK_W-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (en)
            s1_v_reg <= dv_reg[DIV_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_cur_reg  <= cur_d;
            s1_tgt_reg  <= tgt_d;
            s1_mode_reg <= mode_reg[DIV_STEPS-1];
            s1_cura_reg <= shift_mid({1'b0, cur_d}, mid);
            s1_tgta_reg <= shift_mid({1'b0, tgt_d}, mid);
            s1_fwda_reg <= shift_mid(fwd_reg, mid);
            s1_reva_reg <= shift_mid(rev_reg, mid);
        end
    end

    // ---------------- path select ----------------
    logic signed [GOAL_W-1:0] d, goal_c;
    logic                     lim_c;
    logic [TICK_W:0]          up_t, up_c, up_r;

    always_comb
    begin
        up_t = (s1_tgta_reg == '0) ? (TICK_W+1)'(TICKS_PER_TURN) : {1'b0, s1_tgta_reg};
        up_c = (s1_cura_reg == '0) ? (TICK_W+1)'(TICKS_PER_TURN) : {1'b0, s1_cura_reg};
        up_r = (s1_reva_reg == '0) ? (TICK_W+1)'(TICKS_PER_TURN) : {1'b0, s1_reva_reg};
        d     = $signed(GOAL_W'(s1_tgt_reg)) - $signed(GOAL_W'(s1_cur_reg));
        lim_c = 1'b0;
        unique case (s1_mode_reg)
            MODE_SHORTEST:
            begin
                if (d > $signed(GOAL_W'(HALF_TURN)))
                    d = d - GOAL_W'(TICKS_PER_TURN);
                else if (d < -$signed(GOAL_W'(HALF_TURN)))
                    d = d + GOAL_W'(TICKS_PER_TURN);
            end
            MODE_CW:
            begin
                if (d < 0)
                    d = d + GOAL_W'(TICKS_PER_TURN);
            end
            MODE_CCW:
            begin
                if (d > 0)
                    d = d - GOAL_W'(TICKS_PER_TURN);
            end
            default:
            begin
                if (up_t > {1'b0, s1_fwda_reg})
                begin
                    d = $signed(GOAL_W'(s1_fwda_reg)) - $signed(GOAL_W'(s1_cura_reg));
                    if (d < 0 && !(up_c > {1'b0, s1_fwda_reg}))
                        d = d + GOAL_W'(TICKS_PER_TURN);
                    lim_c = 1'b1;
                end
                else if ({1'b0, s1_tgta_reg} < up_r)
                begin
                    d = $signed(GOAL_W'(s1_reva_reg)) - $signed(GOAL_W'(s1_cura_reg));
                    if (d > 0 && !({1'b0, s1_cura_reg} < up_r))
                        d = d - GOAL_W'(TICKS_PER_TURN);
                    lim_c = 1'b1;
                end
            end
        endcase
        goal_c = $signed(GOAL_W'(s1_cur_reg)) + d;
    end

    logic                     s2_v_reg;
    logic signed [GOAL_W-1:0] s2_goal_reg;
    logic                     s2_lim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else if (en)
            s2_v_reg <= s1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_goal_reg <= goal_c;
            s2_lim_reg  <= lim_c;
        end
    end

    // ---------------- scale back to raw, result register ----------------
    logic signed [GOAL_W+REG_W:0] prod;
    logic                         out_v_reg;
    logic signed [GOAL_W-1:0]     goal_ticks_reg;
    logic [RAW_W-1:0]             goal_raw_reg;
    logic                         at_limit_reg;

    assign prod = s2_goal_reg * $signed({1'b0, sc});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= s2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            goal_ticks_reg <= s2_goal_reg;
            goal_raw_reg   <= RAW_W'(prod);
            at_limit_reg   <= s2_lim_reg;
        end
    end

    assign en         = !out_v_reg || out_ready;
    assign in_ready   = en;
    assign out_valid  = out_v_reg;
    assign goal_ticks = goal_ticks_reg;
    assign goal_raw   = goal_raw_reg;
    assign at_limit   = at_limit_reg;

endmodule

/* hw/rtl/sgpp_checker.sv */
// ----------------------------------------------------------------------------
// sgpp_checker
// port level checks of the servo goal position planner
// ----------------------------------------------------------------------------
module sgpp_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [sgpp_pkg::GOAL_W-1:0] goal_ticks,
    input logic [sgpp_pkg::RAW_W-1:0]         goal_raw,
    input logic                               at_limit
);
    import sgpp_pkg::*;

    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(goal_ticks)
            && $stable(goal_raw) && $stable(at_limit))
        else $error("result beat changed while stalled");

    // an empty result register never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with no result pending");

    // a stalled result freezes the pipeline
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while result stalled");

endmodule

bind servo_goal_position_planner sgpp_checker u_sgpp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .goal_ticks (goal_ticks),
    .goal_raw   (goal_raw),
    .at_limit   (at_limit)
);
